// ----- src/arcb_pkg.sv -----
// Shared constants and types for the ARGB squared-space colour blender.
package arcb_pkg;

    localparam int RATIO_FRAC_BITS = 16;
    localparam int RATIO_IN_W      = 20;
    localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
    localparam int CMP_W           = (RATIO_FRAC_BITS + 2 > RATIO_IN_W) ?
                                     RATIO_FRAC_BITS + 2 : RATIO_IN_W;

    localparam int CHAN_W   = 8;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int PROD_W   = RATIO_W + SQ_W;
    localparam int APROD_W  = RATIO_W + CHAN_W;
    localparam int ROOT_W   = CHAN_W;
    localparam int REM_W    = ROOT_W + 2;
    localparam int NCOLOUR  = 3;

    // Three weighting stages followed by four root stages of two bits each.
    localparam int NROOT_STG = ROOT_W / 2;
    localparam int NSTG      = 3 + NROOT_STG;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [ROOT_W-1:0] root_t;
    typedef logic [REM_W-1:0]  rem_t;

    // Register load enables of the weighting stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } arcb_load_t;

endpackage

// ----- src/argb_color_blend_squared_space.sv -----
// Each accepted request passes through every weighting and root stage register before its result reaches the outputs.
// Throughput: one request per cycle while out_stall is low; three weighting stages feed four square root stages.
// Each stage holds its own valid bit and takes new data when it is empty or moving on,
// so bubbles close up while the output is stalled.
// Reset clears all valid bits asynchronously; data registers are not reset.
module argb_color_blend_squared_space (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [31:0]                            from_argb,
    input  logic [31:0]                            to_argb,
    input  logic signed [arcb_pkg::RATIO_IN_W-1:0] blend_ratio,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [7:0]                             out_alpha,
    output logic [7:0]                             out_red,
    output logic [7:0]                             out_green,
    output logic [7:0]                             out_blue
);
    import arcb_pkg::*;

    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG:0]   ready;
    arcb_load_t      wload;

    chan_t w_alpha;
    sq_t   w_val [NCOLOUR];

    sq_t   val_chain  [NCOLOUR][NROOT_STG+1];
    root_t root_chain [NCOLOUR][NROOT_STG+1];
    rem_t  rem_chain  [NCOLOUR][NROOT_STG+1];
    chan_t alpha_reg  [NROOT_STG];

    // A stage takes new data when it is empty or its contents move on downstream.
    always_comb
    begin
        ready[NSTG] = ~out_stall;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            ready[k] = ~vld_reg[k] | ready[k+1];
        end
        vld_next[0] = in_valid;
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (ready[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign wload.s1 = ready[0];
    assign wload.s2 = ready[1];
    assign wload.s3 = ready[2];

    arcb_weight u_weight (
        .clk        (clk),
        .load       (wload),
        .from_argb  (from_argb),
        .to_argb    (to_argb),
        .blend_ratio(blend_ratio),
        .alpha      (w_alpha),
        .colour_val (w_val)
    );

    genvar c, s;
    generate
        for (c = 0; c < NCOLOUR; c++)
        begin : g_colour
            assign val_chain[c][0]  = w_val[c];
            assign root_chain[c][0] = '0;
            assign rem_chain[c][0]  = '0;
            for (s = 0; s < NROOT_STG; s++)
            begin : g_stage
                arcb_root_stage u_root (
                    .clk     (clk),
                    .load    (ready[3+s]),
                    .val_in  (val_chain[c][s]),
                    .root_in (root_chain[c][s]),
                    .rem_in  (rem_chain[c][s]),
                    .val_out (val_chain[c][s+1]),
                    .root_out(root_chain[c][s+1]),
                    .rem_out (rem_chain[c][s+1])
                );
            end
        end
    endgenerate

    // Alpha rides alongside the root stages.
    always_ff @(posedge clk)
    begin
        if (ready[3])
        begin
            alpha_reg[0] <= w_alpha;
        end
        for (int k = 1; k < NROOT_STG; k++)
        begin
            if (ready[3+k])
            begin
                alpha_reg[k] <= alpha_reg[k-1];
            end
        end
    end

    assign in_stall  = ~ready[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_alpha = alpha_reg[NROOT_STG-1];
    assign out_blue  = root_chain[0][NROOT_STG];
    assign out_green = root_chain[1][NROOT_STG];
    assign out_red   = root_chain[2][NROOT_STG];

endmodule

// ----- src/arcb_weight.sv -----
// Ratio clamp, squaring and weighted sums over three register stages.
module arcb_weight (
    input  logic                               clk,
    input  arcb_pkg::arcb_load_t               load,
    input  logic [31:0]                        from_argb,
    input  logic [31:0]                        to_argb,
    input  logic signed [arcb_pkg::RATIO_IN_W-1:0] blend_ratio,
    output arcb_pkg::chan_t                    alpha,
    output arcb_pkg::sq_t                      colour_val [arcb_pkg::NCOLOUR]
);
    import arcb_pkg::*;

    localparam logic signed [CMP_W-1:0] ONE_CMP = CMP_W'(1) <<< RATIO_FRAC_BITS;
    localparam logic [RATIO_W-1:0]      ONE_R   = RATIO_W'(1) << RATIO_FRAC_BITS;

    logic signed [CMP_W-1:0] ratio_ext;
    logic [RATIO_W-1:0]      ratio_clamped;

    // Stage one: clamped ratio, its complement, the squares and raw alpha.
    logic [RATIO_W-1:0] r_reg, r_next;
    logic [RATIO_W-1:0] inv_reg, inv_next;
    chan_t              a0_reg, a1_reg;
    sq_t                sq0_reg [NCOLOUR];
    sq_t                sq1_reg [NCOLOUR];
    sq_t                sq0_next [NCOLOUR];
    sq_t                sq1_next [NCOLOUR];

    // Stage two: products.
    logic [PROD_W-1:0]  p0_reg [NCOLOUR];
    logic [PROD_W-1:0]  p1_reg [NCOLOUR];
    logic [APROD_W-1:0] pa0_reg, pa1_reg;

    // Stage three: sums scaled back to integer range.
    chan_t              alpha_reg;
    sq_t                val_reg [NCOLOUR];
    logic [PROD_W:0]    sum [NCOLOUR];
    logic [APROD_W:0]   asum;

    always_comb
    begin
        ratio_ext = CMP_W'(blend_ratio);
        if (ratio_ext < 0)
        begin
            ratio_clamped = '0;
        end
        else if (ratio_ext > ONE_CMP)
        begin
            ratio_clamped = ONE_R;
        end
        else
        begin
            ratio_clamped = ratio_ext[RATIO_W-1:0];
        end
        r_next   = ratio_clamped;
        inv_next = ONE_R - ratio_clamped;
        for (int c = 0; c < NCOLOUR; c++)
        begin
            sq0_next[c] = SQ_W'(from_argb[c*CHAN_W +: CHAN_W]) *
                          SQ_W'(from_argb[c*CHAN_W +: CHAN_W]);
            sq1_next[c] = SQ_W'(to_argb[c*CHAN_W +: CHAN_W]) *
                          SQ_W'(to_argb[c*CHAN_W +: CHAN_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            r_reg   <= r_next;
            inv_reg <= inv_next;
            a0_reg  <= from_argb[31:24];
            a1_reg  <= to_argb[31:24];
            for (int c = 0; c < NCOLOUR; c++)
            begin
                sq0_reg[c] <= sq0_next[c];
                sq1_reg[c] <= sq1_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s2)
        begin
            pa0_reg <= APROD_W'(inv_reg) * APROD_W'(a0_reg);
            pa1_reg <= APROD_W'(r_reg) * APROD_W'(a1_reg);
            for (int c = 0; c < NCOLOUR; c++)
            begin
                p0_reg[c] <= PROD_W'(inv_reg) * PROD_W'(sq0_reg[c]);
                p1_reg[c] <= PROD_W'(r_reg) * PROD_W'(sq1_reg[c]);
            end
        end
    end

    always_comb
    begin
        asum = (APROD_W + 1)'(pa0_reg) + (APROD_W + 1)'(pa1_reg);
        for (int c = 0; c < NCOLOUR; c++)
        begin
            sum[c] = (PROD_W + 1)'(p0_reg[c]) + (PROD_W + 1)'(p1_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s3)
        begin
            alpha_reg <= asum[RATIO_FRAC_BITS +: CHAN_W];
            for (int c = 0; c < NCOLOUR; c++)
            begin
                val_reg[c] <= sum[c][RATIO_FRAC_BITS +: SQ_W];
            end
        end
    end

    assign alpha = alpha_reg;
    always_comb
    begin
        for (int c = 0; c < NCOLOUR; c++)
        begin
            colour_val[c] = val_reg[c];
        end
    end

endmodule

// ----- src/arcb_root_stage.sv -----
// One register stage of the integer square root, resolving two root bits.
module arcb_root_stage (
    input  logic            clk,
    input  logic            load,
    input  arcb_pkg::sq_t   val_in,
    input  arcb_pkg::root_t root_in,
    input  arcb_pkg::rem_t  rem_in,
    output arcb_pkg::sq_t   val_out,
    output arcb_pkg::root_t root_out,
    output arcb_pkg::rem_t  rem_out
);
    import arcb_pkg::*;

    localparam int WIDE_W = REM_W + 2;

    sq_t   val_reg, val_next;
    root_t root_reg, root_next;
    rem_t  rem_reg, rem_next;

    logic [WIDE_W-1:0] rem_a, trial_a, rem_b, trial_b;
    root_t             root_a;

    // The value is shifted up each stage, so its top four bits are always the next pairs.
    always_comb
    begin
        rem_a   = {rem_in, val_in[SQ_W-1 -: 2]};
        trial_a = {2'b00, root_in, 2'b01};
        if (rem_a >= trial_a)
        begin
            rem_a  = rem_a - trial_a;
            root_a = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            root_a = {root_in[ROOT_W-2:0], 1'b0};
        end

        rem_b   = {rem_a[REM_W-1:0], val_in[SQ_W-3 -: 2]};
        trial_b = {2'b00, root_a, 2'b01};
        if (rem_b >= trial_b)
        begin
            rem_b     = rem_b - trial_b;
            root_next = {root_a[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            root_next = {root_a[ROOT_W-2:0], 1'b0};
        end

        rem_next = rem_b[REM_W-1:0];
        val_next = {val_in[SQ_W-5:0], 4'b0000};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg  <= val_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
        end
    end

    assign val_out  = val_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;

endmodule
